FILE: src/slmm_pkg.sv
// shared types and codes for the sorted list min/max store
package slmm_pkg;

    typedef logic signed [31:0] t_word;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_RMIN   = 2'd1;
    localparam t_op OP_RMAX   = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    localparam int unsigned CNT_OUT_W = 5;

endpackage

FILE: src/slmm_if.sv
// valid/ready channel interfaces for operations and results
interface slmm_in_if;
    logic               valid;
    logic               ready;
    slmm_pkg::t_op      operation;
    slmm_pkg::t_word    value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface slmm_out_if;
    logic                               valid;
    logic                               ready;
    slmm_pkg::t_status                  status;
    slmm_pkg::t_word                    removed_value;
    logic [slmm_pkg::CNT_OUT_W-1:0]     entry_count;

    modport source (output valid, output status, output removed_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input entry_count,
                    output ready);
endinterface

FILE: src/slmm_mem.sv
// entry memory: one write port, one read port with registered read data
module slmm_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  slmm_pkg::t_word     i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output slmm_pkg::t_word     o_rdata
);

    slmm_pkg::t_word r_mem [DEPTH];
    slmm_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/sorted_list_min_max_store.sv
// sorted list min/max store: top level with sequencer and result register
//
// keeps up to CAPACITY signed 32-bit values in ascending order in one memory.
// input channel i_in carries an operation (insert, remove smallest, remove
// largest) and a value; output channel o_out returns one transaction per
// operation with status, removed value and the count held afterwards.
// an operation that needs no memory read (full insert, removal when empty,
// unused code, insert into an empty store) finishes in the accept cycle.
// insert walks from the rear, one entry moved per cycle: each entry not
// below the new value moves up one slot, then the new value fills the gap.
// remove smallest shifts every remaining entry down one slot.
// remove largest reads the rear entry.
// one operation is in work at a time and the next is taken once the
// sequencer is back at idle. results sit in an output register, and a new
// operation can be taken in the same cycle that the previous result is taken;
// i_in.ready drops while that register is full and not being taken.
// reset empties the store at once (count to zero) and clears the result
// valid flag; memory contents need no clearing.
module sorted_list_min_max_store #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    slmm_in_if.sink         i_in,
    slmm_out_if.source      o_out
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_PUT  = 5'b00100,
        S_RMIN = 5'b01000,
        S_RMAX = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [AW-1:0]              r_idx, n_idx;
    slmm_pkg::t_word            r_val, n_val;
    slmm_pkg::t_word            r_removed, n_removed;
    logic                       r_out_vld, n_out_vld;
    slmm_pkg::t_status          r_out_status, n_out_status;
    slmm_pkg::t_word            r_out_removed, n_out_removed;
    logic [CW-1:0]              r_out_count, n_out_count;

    logic                       w_accept;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    slmm_pkg::t_word            w_wdata;
    logic                       w_re;
    logic [AW-1:0]              w_raddr;
    slmm_pkg::t_word            w_rd;

    slmm_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    assign i_in.ready = (r_state == S_IDLE) && (!r_out_vld || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_val         = r_val;
        n_removed     = r_removed;
        n_out_vld     = (r_out_vld && o_out.ready) ? 1'b0 : r_out_vld;
        n_out_status  = r_out_status;
        n_out_removed = r_out_removed;
        n_out_count   = r_out_count;
        w_we          = 1'b0;
        w_waddr       = '0;
        w_wdata       = '0;
        w_re          = 1'b0;
        w_raddr       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in.operation)
                        slmm_pkg::OP_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_out_vld     = 1'b1;
                                n_out_status  = slmm_pkg::ST_FULL;
                                n_out_removed = '0;
                                n_out_count   = r_count;
                            end else if (r_count == '0) begin
                                w_we          = 1'b1;
                                w_waddr       = '0;
                                w_wdata       = i_in.value;
                                n_count       = CW'(1);
                                n_out_vld     = 1'b1;
                                n_out_status  = slmm_pkg::ST_OK;
                                n_out_removed = '0;
                                n_out_count   = CW'(1);
                            end else begin
                                n_val   = i_in.value;
                                n_idx   = AW'(r_count);
                                w_re    = 1'b1;
                                w_raddr = AW'(r_count - CW'(1));
                                n_state = S_INS;
                            end
                        end
                        slmm_pkg::OP_RMIN, slmm_pkg::OP_RMAX: begin
                            if (r_count == '0) begin
                                n_out_vld     = 1'b1;
                                n_out_status  = slmm_pkg::ST_EMPTY;
                                n_out_removed = '0;
                                n_out_count   = '0;
                            end else if (i_in.operation == slmm_pkg::OP_RMIN) begin
                                n_idx   = '0;
                                w_re    = 1'b1;
                                w_raddr = '0;
                                n_state = S_RMIN;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = AW'(r_count - CW'(1));
                                n_state = S_RMAX;
                            end
                        end
                        default: begin
                            n_out_vld     = 1'b1;
                            n_out_status  = slmm_pkg::ST_OK;
                            n_out_removed = '0;
                            n_out_count   = r_count;
                        end
                    endcase
                end
            end
            S_INS: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                if (w_rd >= r_val) begin
                    w_wdata = w_rd;
                    n_idx   = r_idx - AW'(1);
                    if (r_idx == AW'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = r_idx - AW'(1) - AW'(1);
                    end
                end else begin
                    w_wdata       = r_val;
                    n_count       = r_count + CW'(1);
                    n_out_vld     = 1'b1;
                    n_out_status  = slmm_pkg::ST_OK;
                    n_out_removed = '0;
                    n_out_count   = r_count + CW'(1);
                    n_state       = S_IDLE;
                end
            end
            S_PUT: begin
                w_we          = 1'b1;
                w_waddr       = '0;
                w_wdata       = r_val;
                n_count       = r_count + CW'(1);
                n_out_vld     = 1'b1;
                n_out_status  = slmm_pkg::ST_OK;
                n_out_removed = '0;
                n_out_count   = r_count + CW'(1);
                n_state       = S_IDLE;
            end
            S_RMIN: begin
                if (r_idx == '0) begin
                    n_removed = w_rd;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_idx - AW'(1);
                    w_wdata = w_rd;
                end
                if ((CW'(r_idx) + CW'(1)) < r_count) begin
                    w_re    = 1'b1;
                    w_raddr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end else begin
                    n_count       = r_count - CW'(1);
                    n_out_vld     = 1'b1;
                    n_out_status  = slmm_pkg::ST_OK;
                    n_out_removed = (r_idx == '0) ? w_rd : r_removed;
                    n_out_count   = r_count - CW'(1);
                    n_state       = S_IDLE;
                end
            end
            S_RMAX: begin
                n_count       = r_count - CW'(1);
                n_out_vld     = 1'b1;
                n_out_status  = slmm_pkg::ST_OK;
                n_out_removed = w_rd;
                n_out_count   = r_count - CW'(1);
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
        r_idx         <= n_idx;
        r_val         <= n_val;
        r_removed     <= n_removed;
        r_out_status  <= n_out_status;
        r_out_removed <= n_out_removed;
        r_out_count   <= n_out_count;
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.status        = r_out_status;
    assign o_out.removed_value = r_out_removed;
    assign o_out.entry_count   = slmm_pkg::CNT_OUT_W'(r_out_count);

endmodule

FILE: src/slmm_checker.sv
// port-level checks for the sorted list min/max store, bound to the top level
module slmm_checker #(
    parameter int unsigned CAPACITY = 16
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input slmm_pkg::t_status                i_out_status,
    input slmm_pkg::t_word                  i_out_removed,
    input logic [slmm_pkg::CNT_OUT_W-1:0]   i_out_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status == slmm_pkg::ST_OK ||
                         i_out_status == slmm_pkg::ST_EMPTY ||
                         i_out_status == slmm_pkg::ST_FULL))
        else $error("unknown status code");

    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != slmm_pkg::ST_OK |-> i_out_removed == '0)
        else $error("removed value not zero on rejected transaction");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == slmm_pkg::ST_FULL
        |-> i_out_count == slmm_pkg::CNT_OUT_W'(CAPACITY))
        else $error("full status with count below capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == slmm_pkg::ST_EMPTY |-> i_out_count == '0)
        else $error("empty status with nonzero count");

endmodule

bind sorted_list_min_max_store slmm_checker #(
    .CAPACITY (CAPACITY)
) u_slmm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_status  (o_out.status),
    .i_out_removed (o_out.removed_value),
    .i_out_count   (o_out.entry_count)
);
